@@ sv/psg_pkg.sv @@
package psg_pkg;

    localparam int CHANNEL_COUNT = 3;
    localparam int MAX_CHANNELS  = 3;

    // depth must be a power of two, pointers wrap naturally
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [3:0] REG_NOISE_PERIOD = 4'd6;
    localparam logic [3:0] REG_MIXER        = 4'd7;
    localparam logic [3:0] REG_AMP_A        = 4'd8;
    localparam logic [3:0] REG_ENV_FINE     = 4'd11;
    localparam logic [3:0] REG_ENV_COARSE   = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE    = 4'd13;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    typedef struct packed {
        logic       is_write;
        logic       is_shape;
        logic [3:0] addr;
        logic [7:0] data;
    } psg_item_t;

endpackage

@@ sv/psg_tone_noise_envelope.sv @@
// Three-channel sound generator: each request on the slave side is either one generator
// tick (tuser 0) or a byte write to one of sixteen registers (tuser 1, address and data in
// tdata), and every request yields exactly one result carrying the three 4-bit channel
// levels after the mixer, taken after the request's effect. One request is taken per clock
// cycle when the result side keeps up; a request passes an input register, a four-entry
// queue and the output register before its result appears. All dividers, the noise
// lfsr and the envelope ramp update together in the back end when a tick request leaves
// the queue.
module psg_tone_noise_envelope (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // reg_addr[3:0], reg_data[11:4], zero pad
    input  logic        s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // level_a[3:0], level_b[7:4], level_c[11:8], zero pad
);

    logic               fq_valid;
    logic               fq_ready;
    psg_pkg::psg_item_t fq_item;
    logic               qc_valid;
    logic               qc_ready;
    psg_pkg::psg_item_t qc_item;

    psg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_item   (fq_item)
    );

    psg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qc_valid),
        .out_ready (qc_ready),
        .out_item  (qc_item)
    );

    psg_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (qc_valid),
        .q_ready  (qc_ready),
        .q_item   (qc_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ sv/psg_front.sv @@
module psg_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // reg_addr[3:0], reg_data[11:4], zero pad
    input  logic                 s_tuser,   // command
    output logic                 q_valid,
    input  logic                 q_ready,
    output psg_pkg::psg_item_t   q_item
);

    logic               valid_reg;
    logic               valid_next;
    psg_pkg::psg_item_t item_reg;
    psg_pkg::psg_item_t item_next;
    logic               take;

    assign s_tready = !valid_reg || q_ready;
    assign take     = s_tvalid && s_tready;
    assign q_valid  = valid_reg;
    assign q_item   = item_reg;

    always_comb
    begin
        item_next.is_write = (s_tuser == psg_pkg::CMD_WRITE);
        item_next.addr     = s_tdata[3:0];
        item_next.data     = s_tdata[11:4];
        item_next.is_shape = item_next.is_write && (s_tdata[3:0] == psg_pkg::REG_ENV_SHAPE);
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (q_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

endmodule

@@ sv/psg_queue.sv @@
module psg_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  psg_pkg::psg_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output psg_pkg::psg_item_t out_item
);

    psg_pkg::psg_item_t             mem_reg [psg_pkg::QUEUE_DEPTH];
    logic [psg_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [psg_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [psg_pkg::QUEUE_AW:0]     count_reg;
    logic [psg_pkg::QUEUE_AW:0]     count_next;
    logic                           push;
    logic                           pop;

    assign in_ready  = (count_reg != (psg_pkg::QUEUE_AW+1)'(psg_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ sv/psg_core.sv @@
module psg_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  psg_pkg::psg_item_t q_item,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata    // level_a[3:0], level_b[7:4], level_c[11:8], zero pad
);

    localparam int NCH = psg_pkg::MAX_CHANNELS;

    logic [7:0]  regs_reg       [16];
    logic [7:0]  regs_next      [16];
    logic        phase_reg      [NCH];
    logic        phase_next     [NCH];
    logic [14:0] tone_cnt_reg   [NCH];
    logic [14:0] tone_cnt_next  [NCH];
    logic [3:0]  vol_reg        [NCH];
    logic [3:0]  vol_next       [NCH];
    logic [8:0]  noise_cnt_reg;
    logic [8:0]  noise_cnt_next;
    logic [16:0] lfsr_reg;
    logic [16:0] lfsr_next;
    logic [19:0] env_cnt_reg;
    logic [19:0] env_cnt_next;
    logic [3:0]  env_lvl_reg;
    logic [3:0]  env_lvl_next;
    logic [1:0]  env_dir_reg;
    logic [1:0]  env_dir_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic [15:0] m_data_reg;
    logic [15:0] m_data_next;
    logic        pop;

    assign q_ready  = !m_valid_reg || m_tready;
    assign pop      = q_valid && q_ready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // one ramp step, returns {direction, level}
    function automatic logic [5:0] ramp_step(input logic [1:0] dir, input logic [3:0] lvl,
                                             input logic [7:0] shape);
        logic       hold;
        logic       alt;
        logic       cont;
        logic       at_end;
        logic [1:0] d;
        logic [3:0] l;
        hold   = shape[0];
        alt    = shape[1];
        cont   = shape[3];
        d      = dir;
        l      = lvl;
        at_end = (dir == psg_pkg::DIR_DOWN && lvl == 4'd0) ||
                 (dir == psg_pkg::DIR_UP && lvl == 4'd15);
        if (at_end)
        begin
            if (!cont)
            begin
                l = 4'd0;
                d = psg_pkg::DIR_NONE;
            end
            else
            begin
                if (alt)
                begin
                    d = (dir == psg_pkg::DIR_UP) ? psg_pkg::DIR_DOWN : psg_pkg::DIR_UP;
                end
                else
                begin
                    l = (dir == psg_pkg::DIR_UP) ? 4'd0 : 4'd15;
                end
                if (hold)
                begin
                    l = (d == psg_pkg::DIR_UP) ? 4'd15 : 4'd0;
                    d = psg_pkg::DIR_NONE;
                end
            end
        end
        else if (dir == psg_pkg::DIR_UP)
        begin
            l = lvl + 4'd1;
        end
        else if (dir == psg_pkg::DIR_DOWN)
        begin
            l = lvl - 4'd1;
        end
        return {d, l};
    endfunction

    always_comb
    begin
        logic [7:0]  amp;
        logic [11:0] tone_period;
        logic [4:0]  noise_period;
        logic [15:0] env_period;
        logic [5:0]  env_res;
        logic [7:0]  mix;
        logic [3:0]  lvl [NCH];

        regs_next      = regs_reg;
        phase_next     = phase_reg;
        tone_cnt_next  = tone_cnt_reg;
        vol_next       = vol_reg;
        noise_cnt_next = noise_cnt_reg;
        lfsr_next      = lfsr_reg;
        env_cnt_next   = env_cnt_reg;
        env_lvl_next   = env_lvl_reg;
        env_dir_next   = env_dir_reg;
        amp            = '0;
        tone_period    = '0;
        noise_period   = '0;
        env_period     = '0;
        env_res        = '0;

        if (pop && q_item.is_write)
        begin
            regs_next[q_item.addr] = q_item.data;
            if (q_item.is_shape)
            begin
                // shape write restarts the ramp, divider keeps running
                if (q_item.data[2])
                begin
                    env_dir_next = psg_pkg::DIR_UP;
                    env_lvl_next = 4'd0;
                end
                else
                begin
                    env_dir_next = psg_pkg::DIR_DOWN;
                    env_lvl_next = 4'd15;
                end
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < psg_pkg::CHANNEL_COUNT; i++)
            begin
                amp         = regs_reg[4'(int'(psg_pkg::REG_AMP_A) + i)];
                tone_period = {regs_reg[4'(2*i+1)][3:0], regs_reg[4'(2*i)]};
                if (!amp[4])
                begin
                    vol_next[i] = amp[3:0];
                end
                if (amp[4:0] != 5'd0 && tone_period != 12'd0)
                begin
                    if (tone_cnt_reg[i] == 15'd0)
                    begin
                        phase_next[i]    = !phase_reg[i];
                        tone_cnt_next[i] = {tone_period, 3'b000} - 15'd1;
                    end
                    else
                    begin
                        tone_cnt_next[i] = tone_cnt_reg[i] - 15'd1;
                    end
                end
            end

            if (regs_reg[psg_pkg::REG_NOISE_PERIOD] != 8'd0)
            begin
                if (noise_cnt_reg == 9'd0)
                begin
                    noise_period = regs_reg[psg_pkg::REG_NOISE_PERIOD][4:0];
                    if (noise_period == 5'd0)
                    begin
                        noise_period = 5'd1;
                    end
                    lfsr_next      = {lfsr_reg[0] ^ lfsr_reg[3], lfsr_reg[16:1]};
                    noise_cnt_next = {noise_period, 4'b0000} - 9'd1;
                end
                else
                begin
                    noise_cnt_next = noise_cnt_reg - 9'd1;
                end
            end

            if (env_cnt_reg == 20'd0)
            begin
                env_period = {regs_reg[psg_pkg::REG_ENV_COARSE], regs_reg[psg_pkg::REG_ENV_FINE]};
                if (env_period == 16'd0)
                begin
                    env_period = 16'd1;
                end
                env_res      = ramp_step(env_dir_reg, env_lvl_reg,
                                         regs_reg[psg_pkg::REG_ENV_SHAPE]);
                env_dir_next = env_res[5:4];
                env_lvl_next = env_res[3:0];
                for (int i = 0; i < psg_pkg::CHANNEL_COUNT; i++)
                begin
                    if (regs_reg[4'(int'(psg_pkg::REG_AMP_A) + i)][4])
                    begin
                        vol_next[i] = env_res[3:0];
                    end
                end
                env_cnt_next = {env_period, 4'b0000} - 20'd1;
            end
            else
            begin
                env_cnt_next = env_cnt_reg - 20'd1;
            end
        end

        // mixer on the state after this item
        mix = regs_next[psg_pkg::REG_MIXER];
        for (int i = 0; i < NCH; i++)
        begin
            lvl[i] = 4'd0;
        end
        for (int i = 0; i < psg_pkg::CHANNEL_COUNT; i++)
        begin
            if ((phase_next[i] || mix[i]) && (lfsr_next[0] || mix[i+3]))
            begin
                lvl[i] = vol_next[i];
            end
        end
        m_data_next = {4'b0000, lvl[2], lvl[1], lvl[0]};

        if (pop)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                regs_reg[i] <= 8'd0;
            end
            for (int i = 0; i < NCH; i++)
            begin
                phase_reg[i]    <= 1'b0;
                tone_cnt_reg[i] <= 15'd0;
                vol_reg[i]      <= 4'd0;
            end
            noise_cnt_reg <= 9'd0;
            lfsr_reg      <= 17'd1;
            env_cnt_reg   <= 20'd0;
            env_lvl_reg   <= 4'd0;
            env_dir_reg   <= psg_pkg::DIR_NONE;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            regs_reg      <= regs_next;
            phase_reg     <= phase_next;
            tone_cnt_reg  <= tone_cnt_next;
            vol_reg       <= vol_next;
            noise_cnt_reg <= noise_cnt_next;
            lfsr_reg      <= lfsr_next;
            env_cnt_reg   <= env_cnt_next;
            env_lvl_reg   <= env_lvl_next;
            env_dir_reg   <= env_dir_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            m_data_reg <= m_data_next;
        end
    end

    // lfsr can never lock up at zero
    a_lfsr_live: assert property (@(posedge clk) disable iff (!rst_n) lfsr_reg != 17'd0)
        else $error("noise lfsr reached zero");

    // direction code 3 is never produced
    a_dir_legal: assert property (@(posedge clk) disable iff (!rst_n)
        env_dir_reg != 2'd3)
        else $error("envelope direction took the unused code");

    // a stalled result is never overwritten by a new item
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_tready) |-> !pop)
        else $error("result overwritten while stalled");

    // state only moves when an item is consumed
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !pop |=> ($stable(lfsr_reg) && $stable(env_cnt_reg)))
        else $error("generator state moved without an item");

endmodule

@@ verif/psg_tone_noise_envelope_tb.sv @@
module psg_tone_noise_envelope_tb;
    import psg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] REG_TONE_FINE_A = 4'd0;
    localparam logic [3:0] REG_TONE_COARSE_A = 4'd1;
    localparam logic [3:0] REG_TONE_FINE_B = 4'd2;
    localparam logic [3:0] REG_TONE_COARSE_B = 4'd3;
    localparam logic [3:0] REG_TONE_FINE_C = 4'd4;
    localparam logic [3:0] REG_TONE_COARSE_C = 4'd5;
    localparam logic [3:0] REG_AMP_B = 4'd9;
    localparam logic [3:0] REG_AMP_C = 4'd10;
    localparam logic [3:0] REG_PORT_A = 4'd14;
    localparam logic [3:0] REG_PORT_B = 4'd15;

    localparam int SHAPE_HOLD = 0;
    localparam int SHAPE_ALTERNATE = 1;
    localparam int SHAPE_ATTACK = 2;
    localparam int SHAPE_CONTINUE = 3;
    localparam int AMP_ENV_MODE = 4;

    localparam int RANDOM_ITEMS = 830;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_HOLD = 80;

    typedef struct {
        logic        cmd;
        logic [3:0]  addr;
        logic [7:0]  data;
        int unsigned gap;
    } psg_request_t;

    typedef logic [2:0][3:0] psg_levels_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    // predictor state
    logic [7:0]  regs [16];
    logic        tone_ph [3];
    logic [14:0] tone_cnt [3];
    logic [8:0]  noise_cnt;
    logic [16:0] lfsr;
    logic [19:0] env_cnt;
    logic [3:0]  env_lvl;
    logic [1:0]  env_dir;
    logic [3:0]  vol [3];

    psg_request_t pending [$];
    psg_levels_t  levels_due [$];

    psg_request_t cur;
    logic         loaded;
    int unsigned  gap_left;
    int unsigned  accepted;
    int unsigned  total_items;
    int unsigned  rx_wait;
    int unsigned  hold_left;
    int unsigned  results_seen;
    int unsigned  cycle_count;
    int unsigned  error_count;
    logic         tx_idle;

    psg_tone_noise_envelope dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic clear_predictor();
        for (int i = 0; i < 16; i++)
            regs[i] = 8'h00;
        for (int i = 0; i < 3; i++)
        begin
            tone_ph[i] = 1'b0;
            tone_cnt[i] = '0;
            vol[i] = 4'd0;
        end
        noise_cnt = '0;
        lfsr = 17'd1;
        env_cnt = '0;
        env_lvl = 4'd0;
        env_dir = DIR_NONE;
    endtask

    task automatic step_envelope_ramp();
        logic hold;
        logic alternate;
        logic cont;
        logic at_end;
        hold = regs[REG_ENV_SHAPE][SHAPE_HOLD];
        alternate = regs[REG_ENV_SHAPE][SHAPE_ALTERNATE];
        cont = regs[REG_ENV_SHAPE][SHAPE_CONTINUE];
        at_end = (env_dir == DIR_DOWN && env_lvl == 4'd0) ||
                 (env_dir == DIR_UP && env_lvl == 4'd15);
        if (at_end)
        begin
            if (!cont)
            begin
                env_lvl = 4'd0;
                env_dir = DIR_NONE;
            end
            else
            begin
                if (alternate)
                    env_dir = (env_dir == DIR_UP) ? DIR_DOWN : DIR_UP;
                else
                    env_lvl = (env_dir == DIR_UP) ? 4'd0 : 4'd15;
                if (hold)
                begin
                    env_lvl = (env_dir == DIR_UP) ? 4'd15 : 4'd0;
                    env_dir = DIR_NONE;
                end
            end
        end
        else if (env_dir == DIR_UP)
            env_lvl = env_lvl + 4'd1;
        else if (env_dir == DIR_DOWN)
            env_lvl = env_lvl - 4'd1;
    endtask

    task automatic clock_generators();
        logic [7:0]  amp;
        logic [14:0] period;
        logic [4:0]  noise_period;
        logic [15:0] env_period;
        for (int i = 0; i < CHANNEL_COUNT && i < 3; i++)
        begin
            amp = regs[REG_AMP_A + i];
            if (!amp[AMP_ENV_MODE])
                vol[i] = amp[3:0];
            period = {regs[REG_TONE_COARSE_A + 2 * i][3:0], regs[REG_TONE_FINE_A + 2 * i], 3'b000};
            if (amp[4:0] != 5'd0 && period != 15'd0)
            begin
                if (tone_cnt[i] == 15'd0)
                begin
                    tone_ph[i] = ~tone_ph[i];
                    tone_cnt[i] = period;
                end
                tone_cnt[i] = tone_cnt[i] - 15'd1;
            end
        end

        if (regs[REG_NOISE_PERIOD] != 8'h00)
        begin
            if (noise_cnt == 9'd0)
            begin
                lfsr = {lfsr[0] ^ lfsr[3], lfsr[16:1]};
                noise_period = regs[REG_NOISE_PERIOD][4:0];
                if (noise_period == 5'd0)
                    noise_period = 5'd1;
                noise_cnt = {noise_period, 4'b0000};
            end
            noise_cnt = noise_cnt - 9'd1;
        end

        if (env_cnt == 20'd0)
        begin
            step_envelope_ramp();
            for (int i = 0; i < CHANNEL_COUNT && i < 3; i++)
                if (regs[REG_AMP_A + i][AMP_ENV_MODE])
                    vol[i] = env_lvl;
            env_period = {regs[REG_ENV_COARSE], regs[REG_ENV_FINE]};
            if (env_period == 16'd0)
                env_period = 16'd1;
            env_cnt = {env_period, 4'b0000};
        end
        env_cnt = env_cnt - 20'd1;
    endtask

    // advances the predictor by one request and records the levels it should produce
    task automatic apply_request(input logic cmd, input logic [3:0] addr, input logic [7:0] data);
        psg_levels_t lv;
        logic [7:0]  mix;
        if (cmd == CMD_WRITE)
        begin
            regs[addr] = data;
            if (addr == REG_ENV_SHAPE)
            begin
                if (data[SHAPE_ATTACK])
                begin
                    env_dir = DIR_UP;
                    env_lvl = 4'd0;
                end
                else
                begin
                    env_dir = DIR_DOWN;
                    env_lvl = 4'd15;
                end
            end
        end
        else
            clock_generators();

        mix = regs[REG_MIXER];
        for (int i = 0; i < MAX_CHANNELS; i++)
        begin
            lv[i] = 4'd0;
            if (i < CHANNEL_COUNT && (tone_ph[i] | mix[i]) && (lfsr[0] | mix[i + 3]))
                lv[i] = vol[i];
        end
        levels_due.push_back(lv);
    endtask

    task automatic push_request(input logic cmd, input logic [3:0] addr, input logic [7:0] data);
        psg_request_t r;
        r.cmd = cmd;
        r.addr = addr;
        r.data = data;
        r.gap = tx_idle ? $urandom_range(0, 5) : 0;
        pending.push_back(r);
    endtask

    task automatic push_ticks(input int unsigned n);
        for (int k = 0; k < n; k++)
            push_request(CMD_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    endtask

    // register contents kept small so the dividers and the ramp turn over often
    function automatic logic [7:0] pick_reg_data(input logic [3:0] addr);
        logic [7:0] d;
        d = 8'($urandom_range(0, 255));
        case (addr)
            REG_TONE_FINE_A, REG_TONE_FINE_B, REG_TONE_FINE_C:
                if ($urandom_range(0, 15) != 0)
                    d = 8'($urandom_range(0, 15));
            REG_TONE_COARSE_A, REG_TONE_COARSE_B, REG_TONE_COARSE_C:
                d[3:0] = 4'h0;
            REG_NOISE_PERIOD:
                if ($urandom_range(0, 7) != 0)
                    d[4:0] = 5'($urandom_range(0, 3));
            REG_ENV_FINE:
                d = 8'($urandom_range(0, 3));
            REG_ENV_COARSE:
                d = 8'h00;
            default:
                ;
        endcase
        return d;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
            loaded = 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_request(s_tuser, s_tdata[3:0], s_tdata[11:4]);
                accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (!loaded && pending.size() > 0)
                begin
                    cur = pending.pop_front();
                    gap_left = cur.gap;
                    loaded = 1'b1;
                end
                if (loaded && gap_left == 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {4'h0, cur.data, cur.addr};
                    s_tuser <= cur.cmd;
                    loaded = 1'b0;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_wait = 0;
            hold_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (levels_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
                    error_count++;
                end
                else
                begin
                    psg_levels_t want;
                    want = levels_due.pop_front();
                    for (int i = 0; i < MAX_CHANNELS; i++)
                        if (m_tdata[4 * i +: 4] !== want[i])
                        begin
                            $display("%0t: channel %0d level expected %0d, got %0d",
                                     $time, i, want[i], m_tdata[4 * i +: 4]);
                            error_count++;
                        end
                end
                results_seen++;
                // long hold-off so the block fills and stalls its input
                if (results_seen % 300 == 150)
                    hold_left = LONG_HOLD;
                rx_wait = ((results_seen / 100) % 4 != 3) ? $urandom_range(0, 5) : 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("psg_tone_noise_envelope_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [3:0] addr;
        int unsigned target;
        int unsigned n;
        clear_predictor();
        accepted = 0;
        results_seen = 0;
        cycle_count = 0;
        error_count = 0;

        // directed: field extremes, zero periods, ramp shapes, mixer gating
        tx_idle = 1'b1;
        push_request(CMD_TICK, 4'hF, 8'hFF);
        push_request(CMD_WRITE, REG_TONE_FINE_A, 8'hFF);
        push_request(CMD_WRITE, REG_TONE_COARSE_A, 8'hF0);
        push_request(CMD_WRITE, REG_TONE_FINE_B, 8'h01);
        push_request(CMD_WRITE, REG_TONE_FINE_C, 8'h00);
        push_request(CMD_WRITE, REG_NOISE_PERIOD, 8'h20);
        push_request(CMD_WRITE, REG_MIXER, 8'h00);
        push_request(CMD_WRITE, REG_AMP_A, 8'h0F);
        push_request(CMD_WRITE, REG_AMP_B, 8'h1F);
        push_request(CMD_WRITE, REG_AMP_C, 8'hF0);
        push_request(CMD_WRITE, REG_ENV_FINE, 8'h00);
        push_request(CMD_WRITE, REG_ENV_COARSE, 8'h00);
        push_request(CMD_WRITE, REG_ENV_SHAPE, 8'h0E);
        push_request(CMD_WRITE, REG_PORT_A, 8'hFF);
        push_request(CMD_WRITE, REG_PORT_B, 8'h00);
        push_ticks(4);
        push_request(CMD_WRITE, REG_MIXER, 8'hFF);
        push_ticks(2);
        push_request(CMD_WRITE, REG_ENV_SHAPE, 8'h01);
        push_request(CMD_TICK, 4'h0, 8'h00);
        push_request(CMD_WRITE, REG_AMP_A, 8'h00);
        push_request(CMD_TICK, 4'h0, 8'h00);

        // random: short bursts of register writes each followed by a run of ticks
        target = pending.size() + RANDOM_ITEMS;
        while (pending.size() < target)
        begin
            tx_idle = ($urandom_range(0, 2) != 0);
            repeat ($urandom_range(1, 4))
            begin
                addr = ($urandom_range(0, 4) == 0) ? REG_ENV_SHAPE : 4'($urandom_range(0, 15));
                push_request(CMD_WRITE, addr, pick_reg_data(addr));
            end
            if ($urandom_range(0, 4) == 0)
                n = $urandom_range(100, 300);
            else
                n = $urandom_range(1, 40);
            // clip the run so the total item count stays close to the planned count
            if (pending.size() >= target)
                n = 0;
            else if (pending.size() + n > target)
                n = target - pending.size();
            push_ticks(n);
        end

        // long periods last, as once reloaded with them the dividers do not expire again in the run
        tx_idle = 1'b1;
        push_request(CMD_WRITE, REG_TONE_COARSE_A, 8'h0F);
        push_request(CMD_WRITE, REG_AMP_A, 8'h1F);
        push_request(CMD_WRITE, REG_NOISE_PERIOD, 8'h1F);
        push_request(CMD_WRITE, REG_ENV_FINE, 8'hFF);
        push_request(CMD_WRITE, REG_ENV_COARSE, 8'hFF);
        push_ticks(40);
        total_items = pending.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted < total_items || levels_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("psg_tone_noise_envelope_tb: PASS");
        else
            $display("psg_tone_noise_envelope_tb: FAIL");
        $finish;
    end

endmodule
